// ----- src/assert_macros.svh -----
// Assertion macros for the RTL of the breadth-first search block.
// No dependencies; the macros expand to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, pre, post, msg)
`endif
`endif

// ----- src/gbfs_pkg.sv -----
// Types and codes for the breadth-first search block.
// No dependencies; used by every module of the block.
package gbfs_pkg;
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;

    localparam logic [3:0] DIST_MAX = 4'hF;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] from_vertex;
        logic [3:0] to_vertex;
    } t_in;

    typedef struct packed {
        logic [3:0] vertex;
        logic [3:0] distance;
        logic       reachable;
        logic       status;
        logic       last;
    } t_out;
endpackage

// ----- src/gbfs_edge_store.sv -----
// Edge store: destination and next-edge memories with one registered read port.
// Depends on gbfs_pkg.
module gbfs_edge_store import gbfs_pkg::*; #(
    parameter int VW = 4,
    parameter int EW = 6,
    parameter int DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_tgt_we,
    input  logic [EW-1:0] i_tgt_addr,
    input  logic [VW-1:0] i_tgt_data,
    input  logic          i_lnk_we,
    input  logic [EW-1:0] i_lnk_addr,
    input  logic [EW-1:0] i_lnk_data,
    input  logic          i_rd_en,
    input  logic [EW-1:0] i_rd_addr,
    output logic [VW-1:0] o_rd_tgt,
    output logic [EW-1:0] o_rd_lnk
);
    logic [VW-1:0] r_tgt_mem [DEPTH];
    logic [EW-1:0] r_lnk_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_tgt_we) begin
            r_tgt_mem[i_tgt_addr] <= i_tgt_data;
        end
        if (i_lnk_we) begin
            r_lnk_mem[i_lnk_addr] <= i_lnk_data;
        end
        if (i_rd_en) begin
            o_rd_tgt <= r_tgt_mem[i_rd_addr];
            o_rd_lnk <= r_lnk_mem[i_rd_addr];
        end
    end
endmodule

// ----- src/graph_bfs_distances_core.sv -----
// Breadth-first hop distances on a directed graph held as per-vertex edge lists.
// Depends on gbfs_pkg, gbfs_edge_store and assert_macros.svh.
//
// An add or clear transfer gives one acknowledgement. A search walks the queue
// and the edge lists with one shared sequencer: S_DEQ and S_HEAD for each
// reached vertex, S_RD and S_VIS for each edge leaving a reached vertex, S_DEQ
// again to find the queue empty, then S_EMIT and S_OUT for each result row,
// waiting in S_OUT while the output stalls. The edge memory's single read port
// makes each edge a read in S_RD and a check in S_VIS. The input is stalled for
// the whole search and while a result waits at the output.
`include "assert_macros.svh"
module graph_bfs_distances_core import gbfs_pkg::*; #(
    parameter int NUM_VERTICES = 16,
    parameter int MAX_EDGES = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);
    localparam int VW = $clog2(NUM_VERTICES);
    localparam int QW = $clog2(NUM_VERTICES + 1);
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEQ  = 3'd1;
    localparam logic [2:0] S_HEAD = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_VIS  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]          r_state;
    logic [EW-1:0]       r_head [NUM_VERTICES];
    logic [EW-1:0]       r_tail [NUM_VERTICES];
    logic [NUM_VERTICES-1:0] r_hv;
    logic [NUM_VERTICES-1:0] r_vis;
    logic [CW-1:0]       r_cnt;
    logic [QW-1:0]       r_rd;
    logic [QW-1:0]       r_wr;
    logic [VW-1:0]       r_qd;
    logic [VW-1:0]       r_u;
    logic [VW-1:0]       r_v;
    logic [EW-1:0]       r_e;
    logic [3:0]          r_dd;
    logic                r_out_valid;
    t_out                r_out;
    logic [3:0]          r_dist_mem [NUM_VERTICES];
    logic [VW-1:0]       r_q_mem [NUM_VERTICES];

    logic                accept;
    logic                out_free;
    logic                from_ok;
    logic                to_ok;
    logic                full;
    logic [VW-1:0]       src;
    logic [VW-1:0]       dst;
    logic                add_ok;
    logic [VW-1:0]       tgt;
    logic [EW-1:0]       lnk;
    logic                new_vis;
    logic [3:0]          next_d;

    assign o_stall  = (r_state != S_IDLE) || r_out_valid;
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    assign from_ok = {2'b00, i_data.from_vertex} < NUM_VERTICES;
    assign to_ok   = {2'b00, i_data.to_vertex} < NUM_VERTICES;
    assign full    = r_cnt == CW'(MAX_EDGES);
    assign src     = VW'(i_data.from_vertex);
    assign dst     = VW'(i_data.to_vertex);
    assign add_ok  = accept && (i_data.mode == MODE_ADD) && !full && from_ok && to_ok;
    assign new_vis = (r_state == S_VIS) && !r_vis[tgt];
    assign next_d  = (r_dd == DIST_MAX) ? DIST_MAX : r_dd + 4'd1;

    gbfs_edge_store #(.VW(VW), .EW(EW), .DEPTH(MAX_EDGES)) u_edges (
        .i_clk      (i_clk),
        .i_tgt_we   (add_ok),
        .i_tgt_addr (r_cnt[EW-1:0]),
        .i_tgt_data (dst),
        .i_lnk_we   (add_ok && r_hv[src]),
        .i_lnk_addr (r_tail[src]),
        .i_lnk_data (r_cnt[EW-1:0]),
        .i_rd_en    (r_state == S_RD),
        .i_rd_addr  (r_e),
        .o_rd_tgt   (tgt),
        .o_rd_lnk   (lnk)
    );

    always_ff @(posedge i_clk) begin
        if (accept && (i_data.mode == MODE_SEARCH) && from_ok) begin
            r_dist_mem[src] <= 4'd0;
            r_q_mem[0]      <= src;
        end else if (new_vis) begin
            r_dist_mem[tgt]             <= next_d;
            r_q_mem[r_wr[VW-1:0]]       <= tgt;
        end
        if (r_state == S_DEQ) begin
            r_qd <= r_q_mem[r_rd[VW-1:0]];
        end
        if (r_state == S_HEAD) begin
            r_dd <= r_dist_mem[r_qd];
        end else if (r_state == S_EMIT) begin
            r_dd <= r_dist_mem[r_v];
        end
        if (add_ok) begin
            r_tail[src] <= r_cnt[EW-1:0];
            if (!r_hv[src]) begin
                r_head[src] <= r_cnt[EW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hv        <= '0;
            r_vis       <= '0;
            r_cnt       <= '0;
            r_rd        <= '0;
            r_wr        <= '0;
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            if (add_ok) begin
                r_hv[src] <= 1'b1;
                r_cnt     <= r_cnt + CW'(1);
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_data.mode)
                            MODE_ADD: begin
                                r_out_valid <= 1'b1;
                                r_out <= '{vertex: 4'd0, distance: 4'd0, reachable: 1'b0,
                                           status: full, last: 1'b1};
                            end
                            MODE_CLEAR: begin
                                r_hv        <= '0;
                                r_cnt       <= '0;
                                r_out_valid <= 1'b1;
                                r_out <= '{vertex: 4'd0, distance: 4'd0, reachable: 1'b0,
                                           status: 1'b0, last: 1'b1};
                            end
                            MODE_SEARCH: begin
                                r_rd <= '0;
                                r_v  <= '0;
                                if (from_ok) begin
                                    r_vis   <= {{(NUM_VERTICES-1){1'b0}}, 1'b1} << src;
                                    r_wr    <= QW'(1);
                                    r_state <= S_DEQ;
                                end else begin
                                    r_vis   <= '0;
                                    r_wr    <= '0;
                                    r_state <= S_EMIT;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_DEQ: begin
                    if (r_rd == r_wr) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_rd    <= r_rd + QW'(1);
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_u <= r_qd;
                    if (r_hv[r_qd]) begin
                        r_e     <= r_head[r_qd];
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_DEQ;
                    end
                end
                S_RD: begin
                    r_state <= S_VIS;
                end
                S_VIS: begin
                    if (new_vis) begin
                        r_vis[tgt] <= 1'b1;
                        r_wr       <= r_wr + QW'(1);
                    end
                    if (r_e == r_tail[r_u]) begin
                        r_state <= S_DEQ;
                    end else begin
                        r_e     <= lnk;
                        r_state <= S_RD;
                    end
                end
                S_EMIT: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out <= '{vertex: 4'(r_v),
                                   distance: r_vis[r_v] ? r_dd : 4'd0,
                                   reachable: r_vis[r_v],
                                   status: 1'b0,
                                   last: r_v == VW'(NUM_VERTICES - 1)};
                        if (r_v == VW'(NUM_VERTICES - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_v     <= r_v + VW'(1);
                            r_state <= S_EMIT;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_ALWAYS(a_queue_order, r_rd <= r_wr, "queue read pointer passed write pointer")
    `ASSERT_ALWAYS(a_queue_bound, r_wr <= QW'(NUM_VERTICES), "queue overflow")
    `ASSERT_ALWAYS(a_edge_bound, r_cnt <= CW'(MAX_EDGES), "edge count beyond table")
    `ASSERT_IMPLIES(a_busy_stall, r_state != S_IDLE, o_stall, "input taken during search")
endmodule

// ----- bench/testbench.sv -----
// Testbench for graph_bfs_distances_core: edge adds, graph clears and searches
// checked against a behavioral graph predictor. Depends on gbfs_pkg and the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import gbfs_pkg::*;

    localparam int NV = 16;
    localparam int NE = 64;
    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [1:0] MODE_NONE = 2'd3;

    class bfs_scoreboard;
        int edge_dst[NE];
        int first_edge[NV];
        int next_edge[NE];
        int tail_edge[NV];
        int stored_edges;
        t_out pending_rows[$];
        int mismatches;
        int rows_checked;
        int searches;
        int rejects;

        function void wipe();
            for (int v = 0; v < NV; v++) begin
                first_edge[v] = -1;
                tail_edge[v] = -1;
            end
            stored_edges = 0;
        endfunction

        function void note_input(t_in it);
            t_out row;
            int hop_count[NV];
            bit seen[NV];
            int order[$];
            int u;
            int e;
            row = '0;
            row.last = 1'b1;
            case (it.mode)
                MODE_ADD: begin
                    if (stored_edges >= NE) begin
                        row.status = 1'b1;
                        rejects++;
                    end else begin
                        edge_dst[stored_edges] = it.to_vertex;
                        next_edge[stored_edges] = -1;
                        if (first_edge[it.from_vertex] < 0)
                            first_edge[it.from_vertex] = stored_edges;
                        else
                            next_edge[tail_edge[it.from_vertex]] = stored_edges;
                        tail_edge[it.from_vertex] = stored_edges;
                        stored_edges++;
                    end
                    pending_rows.push_back(row);
                end
                MODE_CLEAR: begin
                    wipe();
                    pending_rows.push_back(row);
                end
                MODE_SEARCH: begin
                    searches++;
                    for (int v = 0; v < NV; v++) begin
                        hop_count[v] = 0;
                        seen[v] = 0;
                    end
                    seen[it.from_vertex] = 1;
                    order.push_back(it.from_vertex);
                    while (order.size() > 0) begin
                        u = order.pop_front();
                        e = first_edge[u];
                        while (e >= 0) begin
                            if (!seen[edge_dst[e]]) begin
                                seen[edge_dst[e]] = 1;
                                hop_count[edge_dst[e]] =
                                    (hop_count[u] >= 15) ? 15 : hop_count[u] + 1;
                                order.push_back(edge_dst[e]);
                            end
                            e = next_edge[e];
                        end
                    end
                    for (int v = 0; v < NV; v++) begin
                        row = '0;
                        row.vertex = 4'(v);
                        row.reachable = seen[v];
                        row.distance = seen[v] ? 4'(hop_count[v]) : 4'd0;
                        row.last = (v == NV - 1);
                        pending_rows.push_back(row);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending_rows.size() == 0) begin
                report_mismatch("result with nothing expected", got, '0);
                return;
            end
            want = pending_rows.pop_front();
            rows_checked++;
            if (got.vertex !== want.vertex) report_mismatch("vertex", got, want);
            if (got.distance !== want.distance) report_mismatch("distance", got, want);
            if (got.reachable !== want.reachable) report_mismatch("reachable", got, want);
            if (got.status !== want.status) report_mismatch("status", got, want);
            if (got.last !== want.last) report_mismatch("last", got, want);
        endfunction

        function void report_mismatch(string what, t_out got, t_out want);
            mismatches++;
            $display("mismatch in %s: got %h expected %h", what, got, want);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    bfs_scoreboard board;
    int cycle_count;
    bit hold_output;
    bit long_hold;

    graph_bfs_distances_core dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_result(o_data);
    end

    initial begin
        int gap;
        bit long_done;
        long_done = 0;
        i_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold && !long_done) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                long_done = 1;
            end
            gap = hold_output ? $urandom_range(0, 14) : 0;
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!(o_valid && !i_stall)) @(posedge i_clk);
        end
    end

    task automatic send_item(logic [1:0] mode, logic [3:0] src, logic [3:0] dst, bit pace);
        t_in it;
        int gap;
        it.mode = mode;
        it.from_vertex = src;
        it.to_vertex = dst;
        gap = pace ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            i_data <= t_in'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_input(it);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        i_data <= t_in'($urandom);
        while (board.pending_rows.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_item(bit pace);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            send_item(MODE_ADD, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), pace);
        else if (pick < 66)
            send_item(MODE_CLEAR, 4'($urandom), 4'($urandom), pace);
        else if (pick < 96)
            send_item(MODE_SEARCH, 4'($urandom_range(0, 15)), 4'($urandom), pace);
        else
            send_item(MODE_NONE, 4'($urandom), 4'($urandom), pace);
    endtask

    initial begin
        board = new();
        board.wipe();
        hold_output = 0;
        long_hold = 0;
        i_valid = 1'b0;
        i_data = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(MODE_SEARCH, 4'd0, 4'd0, 0);
        send_item(MODE_ADD, 4'd0, 4'd15, 0);
        send_item(MODE_ADD, 4'd15, 4'd15, 0);
        send_item(MODE_ADD, 4'd15, 4'd0, 0);
        send_item(MODE_ADD, 4'd0, 4'd15, 0);
        send_item(MODE_NONE, 4'hF, 4'hF, 0);
        send_item(MODE_SEARCH, 4'd0, 4'hF, 0);
        send_item(MODE_SEARCH, 4'd15, 4'd0, 0);
        send_item(MODE_CLEAR, 4'hF, 4'hF, 0);
        for (int v = 0; v < 15; v++)
            send_item(MODE_ADD, 4'(v), 4'(v + 1), 0);
        send_item(MODE_SEARCH, 4'd0, 4'd0, 0);
        drain();

        // Fill the edge table and push past it to provoke rejects.
        for (int k = 0; k < 70; k++)
            send_item(MODE_ADD, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), k[0]);
        send_item(MODE_SEARCH, 4'($urandom_range(0, 15)), 4'd0, 0);
        send_item(MODE_CLEAR, 4'd0, 4'd0, 0);

        hold_output = 1;
        long_hold = 1;
        for (int k = 0; k < 20; k++)
            random_item(0);
        drain();

        for (int k = 0; k < 200; k++) begin
            if (k % 40 == 0) begin
                send_item(MODE_CLEAR, 4'd0, 4'd0, 1);
                for (int j = 0; j < 15; j++)
                    send_item(MODE_ADD, 4'(j), 4'(j + 1), 0);
            end
            random_item((k / 50) % 2 == 0);
        end
        drain();

        $display("ran %0d searches, %0d rejected adds, %0d result rows checked",
                 board.searches, board.rejects, board.rows_checked);
        if (board.mismatches == 0 && board.pending_rows.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
